@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the sphere tessellator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define SMT_ASSERT_IMPLIES(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define SMT_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/smt_pkg.sv @@
// Shared types, codes and constants for the sphere tessellator.
// No dependencies; imported by smt_front, smt_queue, smt_back, the top and the bench.
package smt_pkg;

  localparam int SEG_W      = 9;
  localparam int CELL_W     = 8;
  localparam int PHASE_W    = 17;
  localparam int TEX_W      = 16;
  localparam int POS_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int QUEUE_DEPTH = 8;
  localparam int VERTS_PER_CELL = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS_AROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS_DOWN   = 2'd1;
  localparam logic [SEG_W-1:0] SEG_AROUND_RESET = 9'd32;
  localparam logic [SEG_W-1:0] SEG_DOWN_RESET   = 9'd16;

  // divider op codes, issued in this order per grid cell (only OP_TEX_HI off the grid)
  localparam logic [1:0] OP_PHASE_LO = 2'd0;
  localparam logic [1:0] OP_PHASE_HI = 2'd1;
  localparam logic [1:0] OP_TEX_LO   = 2'd2;
  localparam logic [1:0] OP_TEX_HI   = 2'd3;

  // corner order per row parity
  localparam logic [1:0] ORDER_EVEN [VERTS_PER_CELL] = '{2'd2, 2'd0, 2'd1, 2'd2, 2'd1, 2'd3};
  localparam logic [1:0] ORDER_ODD  [VERTS_PER_CELL] = '{2'd2, 2'd0, 2'd3, 2'd3, 2'd0, 2'd1};

  // sine table build: Q2.62 Taylor series
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam int TAYLOR_TERMS = 15;
  localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
    64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930};

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  typedef struct packed {
    logic [1:0] op;
    logic       last;
    logic       bad;
    logic       odd;
  } tag_t;

  // one cell's divided values, ready for the vertex sequencer
  typedef struct packed {
    logic [PHASE_W-1:0] pu0;
    logic [PHASE_W-1:0] pu1;
    logic [PHASE_W-1:0] pv0;
    logic [PHASE_W-1:0] pv1;
    logic [TEX_W-1:0]   tu0;
    logic [TEX_W-1:0]   tu1;
    logic [TEX_W-1:0]   tv0;
    logic [TEX_W-1:0]   tv1;
    logic               odd;
    logic               bad;
  } rec_t;

endpackage

@@ rtl/smt_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, one op per cycle.
// Depends on nothing; tag rides alongside the operands.
module smt_div #(
  parameter int NW = 26,
  parameter int DW = 10,
  parameter int QW = 16,
  parameter int TW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] tag_out
);

  localparam int EW = NW + DW + QW;

  logic          v   [QW+1];
  logic [NW-1:0] rem [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic [TW-1:0] tg  [QW+1];

  assign v[0]   = in_valid;
  assign rem[0] = num;
  assign dv[0]  = den;
  assign q[0]   = '0;
  assign tg[0]  = tag_in;

  // stage s settles quotient bit QW-1-s
  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [EW-1:0] shifted;
    logic          fits;
    assign shifted = EW'(dv[s]) << B;
    assign fits    = EW'(rem[s]) >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      rem[s+1] <= fits ? NW'(EW'(rem[s]) - shifted) : rem[s];
      dv[s+1]  <= dv[s];
      q[s+1]   <= q[s] | (QW'(fits) << B);
      tg[s+1]  <= tg[s];
    end
  end

  assign out_valid = v[QW];
  assign quo       = q[QW];
  assign tag_out   = tg[QW];

endmodule

@@ rtl/smt_front.sv @@
// Front end: takes a cell, classifies it, issues its divider ops.
// Depends on smt_pkg; feeds two smt_div lanes (columns and rows).
module smt_front #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int NW = 26
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [smt_pkg::CELL_W-1:0]  cell_col,
  input  logic [smt_pkg::CELL_W-1:0]  cell_row,
  input  logic [smt_pkg::SEG_W-1:0]   seg_around,
  input  logic [smt_pkg::SEG_W-1:0]   seg_down,
  input  logic                        credit_full,
  output logic                        busy,
  output logic                        op_valid,
  output logic [NW-1:0]               num_col,
  output logic [NW-1:0]               num_row,
  output logic [smt_pkg::SEG_W:0]     den_col,
  output logic [smt_pkg::SEG_W:0]     den_row,
  output smt_pkg::tag_t               tag
);
  import smt_pkg::*;

  logic              active;
  logic [1:0]        cnt;
  logic [CELL_W-1:0] col;
  logic [CELL_W-1:0] row;
  logic              bad;
  logic              bad_now;
  logic              accept;
  logic              hi;
  logic [SEG_W-1:0]  c_sel;
  logic [SEG_W-1:0]  r_sel;

  // outside the grid, or an empty grid
  assign bad_now = (seg_around == '0) || (seg_down == '0) ||
                   ({1'b0, cell_col} >= seg_around) || ({1'b0, cell_row} >= seg_down);

  // free again in the cycle of the last issue, unless the queue credits run out
  assign busy   = (active && (cnt != OP_TEX_HI)) || credit_full;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= OP_PHASE_LO;
    end else if (accept) begin
      active <= 1'b1;
      cnt    <= bad_now ? OP_TEX_HI : OP_PHASE_LO;
    end else if (active) begin
      if (cnt == OP_TEX_HI) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col <= cell_col;
      row <= cell_row;
      bad <= bad_now;
    end
  end

  // operands for the current op
  assign hi    = (cnt == OP_PHASE_HI) || (cnt == OP_TEX_HI);
  assign c_sel = {1'b0, col} + SEG_W'(hi);
  assign r_sel = {1'b0, row} + SEG_W'(hi);

  always_comb begin
    if ((cnt == OP_PHASE_LO) || (cnt == OP_PHASE_HI)) begin
      num_col = NW'(c_sel) * NW'(8 * SINE_TABLE_DEPTH) + NW'(seg_around);
      num_row = NW'(r_sel) * NW'(4 * SINE_TABLE_DEPTH) + NW'(seg_down);
    end else begin
      num_col = (NW'(c_sel) << 16) + NW'(seg_around);
      num_row = (NW'(r_sel) << 16) + NW'(seg_down);
    end
  end

  assign op_valid = active;
  assign den_col  = {seg_around, 1'b0};
  assign den_row  = {seg_down, 1'b0};
  assign tag.op   = cnt;
  assign tag.last = (cnt == OP_TEX_HI);
  assign tag.bad  = bad;
  assign tag.odd  = row[0];

endmodule

@@ rtl/smt_queue.sv @@
// Collects divider results into cell records and queues them for the back end.
// Depends on smt_pkg; sits between the divider lanes and smt_back.
module smt_queue #(
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [QW-1:0] q_col,
  input  logic [QW-1:0] q_row,
  input  smt_pkg::tag_t tag,
  input  logic          pop,
  output smt_pkg::rec_t head,
  output logic          nonempty
);
  import smt_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [PHASE_W-1:0] pu0, pv0, pu1, pv1;
  logic [TEX_W-1:0]   tu0, tv0;
  rec_t               rec;
  logic               push;
  rec_t               fifo [QUEUE_DEPTH];
  logic [PW-1:0]      wp;
  logic [PW-1:0]      rp;
  logic [PW:0]        count;

  // partial results of the cell in flight
  always_ff @(posedge clk) begin
    if (in_valid) begin
      case (tag.op)
        OP_PHASE_LO: begin
          pu0 <= PHASE_W'(q_col);
          pv0 <= PHASE_W'(q_row);
        end
        OP_PHASE_HI: begin
          pu1 <= PHASE_W'(q_col);
          pv1 <= PHASE_W'(q_row);
        end
        OP_TEX_LO: begin
          tu0 <= TEX_W'(q_col);
          tv0 <= TEX_W'(q_row);
        end
        default: begin
        end
      endcase
    end
  end

  assign push = in_valid && tag.last;

  always_comb begin
    rec.pu0 = pu0;
    rec.pu1 = pu1;
    rec.pv0 = pv0;
    rec.pv1 = pv1;
    rec.tu0 = tu0;
    rec.tu1 = TEX_W'(q_col);
    rec.tv0 = tv0;
    rec.tv1 = TEX_W'(q_row);
    rec.odd = tag.odd;
    rec.bad = tag.bad;
  end

  // record fifo; credits upstream keep it from overflowing
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assign head     = fifo[rp];
  assign nonempty = (count != '0);

endmodule

@@ rtl/smt_back.sv @@
// Back end: walks six corners per good record, reads sine ROMs, forms vertices.
// Depends on smt_pkg; drives the block's result ports from registers.
module smt_back #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRAC_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  smt_pkg::rec_t                head,
  input  logic                         nonempty,
  output logic                         pop,
  output logic                         strobe,
  output logic signed [smt_pkg::POS_W-1:0] pos_x,
  output logic signed [smt_pkg::POS_W-1:0] pos_y,
  output logic signed [smt_pkg::POS_W-1:0] pos_z,
  output logic [smt_pkg::TEX_W-1:0]    tex_u,
  output logic [smt_pkg::TEX_W-1:0]    tex_v,
  output logic [1:0]                   corner,
  output logic                         last,
  output logic                         bad_cell
);
  import smt_pkg::*;

  localparam int D    = SINE_TABLE_DEPTH;
  localparam int AW   = $clog2(D + 1);
  localparam int MW   = FRAC_BITS + 1;
  localparam int PRW  = 2 * MW;
  localparam int XW   = PHASE_W + 1;
  localparam int RSH2 = 2 * FRAC_BITS - 15;
  localparam int RSH1 = (FRAC_BITS > 15) ? FRAC_BITS - 15 : 0;
  localparam int LSH1 = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
  localparam logic [PRW-1:0] HALF2 = PRW'(1) << (RSH2 - 1);
  localparam logic [31:0]    HALF1 = (RSH1 > 0) ? (32'd1 << (RSH1 - 1)) : 32'd0;

  typedef logic [MW-1:0] rom_t [D+1];

  typedef struct packed {
    logic          neg;
    logic [AW-1:0] addr;
  } look_t;

  // quarter-wave table, round(sin(pi/2 * i / D) * 2^FRAC_BITS)
  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] step, x, x2, term, sum, v;
    step = HALF_PI_Q62 / SINE_TABLE_DEPTH;
    for (int i = 0; i <= D; i++) begin
      x    = step * 64'(i);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        term = mul_q62(term, x2) / TAYLOR_DIV[k];
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
      if (v > (64'd1 << FRAC_BITS)) begin
        v = 64'd1 << FRAC_BITS;
      end
      t[i] = v[MW-1:0];
    end
    return t;
  endfunction

  localparam rom_t ROM_U = build_rom();
  localparam rom_t ROM_V = build_rom();

  // fold a phase into a table address and a sign
  function automatic look_t lookup(input logic [XW-1:0] p);
    look_t         lk;
    logic [XW-1:0] pm;
    logic [XW-1:0] r;
    logic [1:0]    q;
    pm = (p >= XW'(4 * D)) ? p - XW'(4 * D) : p;
    if (pm >= XW'(3 * D)) begin
      q = 2'd3;
      r = pm - XW'(3 * D);
    end else if (pm >= XW'(2 * D)) begin
      q = 2'd2;
      r = pm - XW'(2 * D);
    end else if (pm >= XW'(D)) begin
      q = 2'd1;
      r = pm - XW'(D);
    end else begin
      q = 2'd0;
      r = pm;
    end
    lk.neg  = q[1];
    lk.addr = q[0] ? AW'(XW'(D) - r) : AW'(r);
    return lk;
  endfunction

  // apply the sign to a magnitude, saturating positive results to Q1.15
  function automatic logic [POS_W-1:0] pack(input logic neg, input logic [16:0] mag);
    logic [POS_W-1:0] res;
    if (neg && (mag != '0)) begin
      res = POS_W'(~mag + 17'd1);
    end else if (mag > 17'd32767) begin
      res = 16'h7fff;
    end else begin
      res = mag[POS_W-1:0];
    end
    return res;
  endfunction

  // corner sequencer
  logic       have;
  rec_t       cur;
  logic [2:0] vcnt;
  logic       fin;

  assign fin = have && (cur.bad || (vcnt == 3'(VERTS_PER_CELL - 1)));
  assign pop = nonempty && (!have || fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      vcnt <= '0;
    end else if (pop) begin
      have <= 1'b1;
      vcnt <= '0;
    end else if (fin) begin
      have <= 1'b0;
    end else if (have) begin
      vcnt <= vcnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // corner select and phase folding
  logic [1:0]         cn;
  logic [PHASE_W-1:0] pu, pv;
  look_t              lk_su, lk_cu, lk_sv, lk_cv;

  assign cn = cur.odd ? ORDER_ODD[vcnt] : ORDER_EVEN[vcnt];
  assign pu = cn[0] ? cur.pu1 : cur.pu0;
  assign pv = cn[1] ? cur.pv1 : cur.pv0;
  assign lk_su = lookup({1'b0, pu});
  assign lk_cu = lookup({1'b0, pu} + XW'(D));
  assign lk_sv = lookup({1'b0, pv});
  assign lk_cv = lookup({1'b0, pv} + XW'(D));

  // stage 1: table reads
  logic             s1_valid;
  logic [MW-1:0]    s1_su, s1_cu, s1_sv, s1_cv;
  logic             s1_nsu, s1_ncu, s1_nsv, s1_ncv;
  logic [1:0]       s1_corner;
  logic             s1_last, s1_bad;
  logic [TEX_W-1:0] s1_tu, s1_tv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= have;
    end
  end

  always_ff @(posedge clk) begin
    s1_su     <= ROM_U[lk_su.addr];
    s1_cu     <= ROM_U[lk_cu.addr];
    s1_sv     <= ROM_V[lk_sv.addr];
    s1_cv     <= ROM_V[lk_cv.addr];
    s1_nsu    <= lk_su.neg;
    s1_ncu    <= lk_cu.neg;
    s1_nsv    <= lk_sv.neg;
    s1_ncv    <= lk_cv.neg;
    s1_corner <= cn;
    s1_last   <= fin;
    s1_bad    <= cur.bad;
    s1_tu     <= cn[0] ? cur.tu1 : cur.tu0;
    s1_tv     <= cn[1] ? cur.tv1 : cur.tv0;
  end

  // stage 2: products
  logic             s2_valid;
  logic [PRW-1:0]   s2_px, s2_pz;
  logic [MW-1:0]    s2_cv;
  logic             s2_nx, s2_nz, s2_ny;
  logic [1:0]       s2_corner;
  logic             s2_last, s2_bad;
  logic [TEX_W-1:0] s2_tu, s2_tv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_px     <= PRW'(s1_cu) * PRW'(s1_sv);
    s2_pz     <= PRW'(s1_su) * PRW'(s1_sv);
    s2_cv     <= s1_cv;
    s2_nx     <= s1_ncu ^ s1_nsv;
    s2_nz     <= s1_nsu ^ s1_nsv;
    s2_ny     <= s1_ncv;
    s2_corner <= s1_corner;
    s2_last   <= s1_last;
    s2_bad    <= s1_bad;
    s2_tu     <= s1_tu;
    s2_tv     <= s1_tv;
  end

  // stage 3: round to Q1.15, saturate, register the result
  logic [16:0] mag_x, mag_y, mag_z;

  assign mag_x = 17'((s2_px + HALF2) >> RSH2);
  assign mag_z = 17'((s2_pz + HALF2) >> RSH2);
  assign mag_y = 17'(((32'(s2_cv) + HALF1) >> RSH1) << LSH1);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_bad) begin
      pos_x    <= '0;
      pos_y    <= '0;
      pos_z    <= '0;
      tex_u    <= '0;
      tex_v    <= '0;
      corner   <= '0;
      last     <= 1'b1;
      bad_cell <= 1'b1;
    end else begin
      pos_x    <= pack(s2_nx, mag_x);
      pos_y    <= pack(s2_ny, mag_y);
      pos_z    <= pack(s2_nz, mag_z);
      tex_u    <= s2_tu;
      tex_v    <= s2_tv;
      corner   <= s2_corner;
      last     <= s2_last;
      bad_cell <= 1'b0;
    end
  end

endmodule

@@ rtl/sphere_mesh_tessellator.sv @@
// Top level of the UV sphere tessellator: config registers, credit count, wiring.
// Depends on smt_pkg, smt_front, smt_div, smt_queue, smt_back, assert_macros.svh.

// A cell (cell_col, cell_row) is taken at a clock edge with start high and busy low.
// It yields six vertices on consecutive cycles, each marked by strobe for one
// cycle (last on the sixth); a cell off the grid yields one word with bad_cell and
// last set. The result port carries one vertex per cycle while records are queued;
// the front end is free again in the cycle of its last divider issue, OP_TEX_HI,
// which follows OP_PHASE_LO to OP_TEX_LO for a grid cell and comes alone for a cell
// off the grid, unless credits run out; it runs ahead by up to eight queued cells.
// A cell's ops pass both pipelined divider lanes (depth QW, 16 at default settings),
// the record queue and the back end. The receiver cannot stall; segments_around and
// segments_down must be written only while idle, which the block does not enforce.
`include "assert_macros.svh"

module sphere_mesh_tessellator #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRAC_BITS = 15,
  parameter int MAX_SEGMENTS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [smt_pkg::CELL_W-1:0]       cell_col,
  input  logic [smt_pkg::CELL_W-1:0]       cell_row,
  input  logic                             wr_en,
  input  logic [smt_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [smt_pkg::SEG_W-1:0]        wr_data,
  output logic                             strobe,
  output logic signed [smt_pkg::POS_W-1:0] pos_x,
  output logic signed [smt_pkg::POS_W-1:0] pos_y,
  output logic signed [smt_pkg::POS_W-1:0] pos_z,
  output logic [smt_pkg::TEX_W-1:0]        tex_u,
  output logic [smt_pkg::TEX_W-1:0]        tex_v,
  output logic [1:0]                       corner,
  output logic                             last,
  output logic                             bad_cell
);
  import smt_pkg::*;

  localparam int PBITS = $clog2(4 * SINE_TABLE_DEPTH + 1);
  localparam int QW    = (PBITS > TEX_W) ? PBITS : TEX_W;
  localparam int NBITS = SEG_W + $clog2(8 * SINE_TABLE_DEPTH);
  localparam int NW    = ((NBITS > SEG_W + 16) ? NBITS : SEG_W + 16) + 1;
  localparam int DW    = SEG_W + 1;
  localparam int TW    = $bits(tag_t);
  localparam int ALLOC_W = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [SEG_W-1:0] seg_around_r, seg_down_r;
  logic [SEG_W-1:0] seg_around, seg_down;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_around_r <= SEG_AROUND_RESET;
      seg_down_r   <= SEG_DOWN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_SEGMENTS_AROUND: seg_around_r <= wr_data;
        REG_SEGMENTS_DOWN:   seg_down_r   <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // counts above the limit behave as the limit
  assign seg_around = (32'(seg_around_r) > MAX_SEGMENTS) ? SEG_W'(MAX_SEGMENTS) : seg_around_r;
  assign seg_down   = (32'(seg_down_r) > MAX_SEGMENTS) ? SEG_W'(MAX_SEGMENTS) : seg_down_r;

  // queue credits: cells taken and not yet popped by the back end
  logic [ALLOC_W-1:0] alloc;
  logic               credit_full;
  logic               accept;
  logic               q_pop;
  logic               q_nonempty;

  assign credit_full = (alloc == ALLOC_W'(QUEUE_DEPTH));
  assign accept      = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc <= '0;
    end else begin
      alloc <= alloc + ALLOC_W'(accept) - ALLOC_W'(q_pop);
    end
  end

  // front end
  logic          op_valid;
  logic [NW-1:0] num_col, num_row;
  logic [DW-1:0] den_col, den_row;
  tag_t          op_tag;

  smt_front #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .NW(NW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cell_col(cell_col),
    .cell_row(cell_row),
    .seg_around(seg_around),
    .seg_down(seg_down),
    .credit_full(credit_full),
    .busy(busy),
    .op_valid(op_valid),
    .num_col(num_col),
    .num_row(num_row),
    .den_col(den_col),
    .den_row(den_row),
    .tag(op_tag)
  );

  // divider lanes
  logic          dc_valid, dr_valid;
  logic [QW-1:0] q_col, q_row;
  logic [TW-1:0] dc_tag, dr_tag;

  smt_div #(.NW(NW), .DW(DW), .QW(QW), .TW(TW)) u_div_col (
    .clk(clk),
    .rst(rst),
    .in_valid(op_valid),
    .num(num_col),
    .den(den_col),
    .tag_in(op_tag),
    .out_valid(dc_valid),
    .quo(q_col),
    .tag_out(dc_tag)
  );

  smt_div #(.NW(NW), .DW(DW), .QW(QW), .TW(TW)) u_div_row (
    .clk(clk),
    .rst(rst),
    .in_valid(op_valid),
    .num(num_row),
    .den(den_row),
    .tag_in(op_tag),
    .out_valid(dr_valid),
    .quo(q_row),
    .tag_out(dr_tag)
  );

  // record queue
  rec_t q_head;

  smt_queue #(.QW(QW)) u_queue (
    .clk(clk),
    .rst(rst),
    .in_valid(dc_valid),
    .q_col(q_col),
    .q_row(q_row),
    .tag(tag_t'(dc_tag)),
    .pop(q_pop),
    .head(q_head),
    .nonempty(q_nonempty)
  );

  // back end
  smt_back #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .head(q_head),
    .nonempty(q_nonempty),
    .pop(q_pop),
    .strobe(strobe),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .tex_u(tex_u),
    .tex_v(tex_v),
    .corner(corner),
    .last(last),
    .bad_cell(bad_cell)
  );

  // checks
  `SMT_ASSERT_IMPLIES(a_credit_bound, clk, rst, 1'b1, alloc <= ALLOC_W'(QUEUE_DEPTH), "credit count over queue depth")
  `SMT_ASSERT_IMPLIES(a_pop_nonempty, clk, rst, q_pop, q_nonempty, "pop from empty record queue")
  `SMT_ASSERT_IMPLIES(a_lanes_aligned, clk, rst, dc_valid || dr_valid, dc_valid && dr_valid && (dc_tag == dr_tag), "divider lanes out of step")
  `SMT_ASSERT_IMPLIES(a_bad_single, clk, rst, strobe && bad_cell, last && (corner == 2'd0) && (pos_x == '0), "bad cell word malformed")
  `SMT_ASSERT_NEXT(a_accept_credit, clk, rst, accept, alloc != '0, "accepted cell holds no credit")

endmodule

@@ tb/sphere_mesh_tessellator_tb.sv @@
// Self-checking testbench for sphere_mesh_tessellator: directed and random cells on and
// off the grid over several segment settings. Depends on smt_pkg and the block's RTL.
module sphere_mesh_tessellator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smt_pkg::*;

  localparam int TBL_DEPTH = 1024;
  localparam int SEG_LIMIT = 256;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [15:0] x, y, z, u, v;
    logic [1:0]  crn;
    logic        lst, bad;
  } vertex_t;

  // Scoreboard: predicts the vertices of each accepted cell and checks the output words
  class tess_scoreboard;
    longint signed sine_tbl[TBL_DEPTH + 1];
    vertex_t       vert_q[$];
    int            seg_around, seg_down;
    int            errors, words_seen, cells_seen, bad_seen;

    function longint unsigned mulq62(longint unsigned a, longint unsigned b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
    endfunction

    function new();
      longint unsigned stp, xx, x2, term, sum, v;
      stp = 64'h6487ED5110B4611A / TBL_DEPTH;
      for (int i = 0; i <= TBL_DEPTH; i++) begin
        xx = stp * i;
        x2 = mulq62(xx, xx);
        term = xx;
        sum = xx;
        for (int k = 1; k <= 15; k++) begin
          term = mulq62(term, x2) / ((2 * k) * (2 * k + 1));
          if (k & 1) sum -= term;
          else sum += term;
        end
        v = (sum + (64'd1 << 46)) >> 47;
        if (v > 32768) v = 32768;
        sine_tbl[i] = v;
      end
      seg_around = 32;
      seg_down = 16;
    endfunction

    function longint signed sine_at(longint unsigned ph);
      longint unsigned p, q, r;
      longint signed m;
      p = ph % (4 * TBL_DEPTH);
      q = p / TBL_DEPTH;
      r = p % TBL_DEPTH;
      m = (q & 1) ? sine_tbl[TBL_DEPTH - r] : sine_tbl[r];
      return (q >= 2) ? -m : m;
    endfunction

    function logic [15:0] to_signed16(bit neg, longint unsigned mag);
      if (!neg && mag > 32767) mag = 32767;
      if (neg && mag > 32768) mag = 32768;
      return neg ? 16'(65536 - mag) : 16'(mag);
    endfunction

    function logic [15:0] mul_round(longint signed a, longint signed b);
      longint unsigned ma, mb, mag;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      mag = (ma * mb + (64'd1 << 14)) >> 15;
      return to_signed16(mag != 0 && ((a < 0) != (b < 0)), mag);
    endfunction

    function vertex_t corner_vertex(longint unsigned c, longint unsigned r,
                                    longint unsigned sa, longint unsigned sd);
      vertex_t vx;
      longint unsigned pu, pv, ymag;
      longint signed su, cu, sv, cv;
      pu = (c * 8 * TBL_DEPTH + sa) / (2 * sa);
      pv = (r * 4 * TBL_DEPTH + sd) / (2 * sd);
      su = sine_at(pu);
      cu = sine_at(pu + TBL_DEPTH);
      sv = sine_at(pv);
      cv = sine_at(pv + TBL_DEPTH);
      ymag = (cv < 0) ? -cv : cv;
      vx.x = mul_round(cu, sv);
      vx.y = to_signed16(ymag != 0 && cv < 0, ymag);
      vx.z = mul_round(su, sv);
      vx.u = 16'(((c << 16) + sa) / (2 * sa));
      vx.v = 16'(((r << 16) + sd) / (2 * sd));
      return vx;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, int val);
      if (idx == REG_SEGMENTS_AROUND) seg_around = val & 'h1FF;
      else if (idx == REG_SEGMENTS_DOWN) seg_down = val & 'h1FF;
    endfunction

    // accepted cell: queue its expected words
    function void note_cell(int col, int row);
      int sa, sd, cn;
      vertex_t vx;
      sa = (seg_around > SEG_LIMIT) ? SEG_LIMIT : seg_around;
      sd = (seg_down > SEG_LIMIT) ? SEG_LIMIT : seg_down;
      cells_seen++;
      if (sa == 0 || sd == 0 || col >= sa || row >= sd) begin
        vx = '{default: '0};
        vx.lst = 1'b1;
        vx.bad = 1'b1;
        vert_q = {vert_q, vx};
        bad_seen++;
        return;
      end
      for (int k = 0; k < VERTS_PER_CELL; k++) begin
        cn = (row & 1) ? ORDER_ODD[k] : ORDER_EVEN[k];
        vx = corner_vertex(col + (cn & 1), row + (cn >> 1), sa, sd);
        vx.crn = 2'(cn);
        vx.lst = (k == VERTS_PER_CELL - 1);
        vx.bad = 1'b0;
        vert_q = {vert_q, vx};
      end
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_word(vertex_t got);
      vertex_t ex;
      words_seen++;
      if (vert_q.size() == 0) begin
        report("output word with nothing pending");
        return;
      end
      ex = vert_q.pop_front();
      if (got.x !== ex.x) report($sformatf("pos_x %h exp %h", got.x, ex.x));
      if (got.y !== ex.y) report($sformatf("pos_y %h exp %h", got.y, ex.y));
      if (got.z !== ex.z) report($sformatf("pos_z %h exp %h", got.z, ex.z));
      if (got.u !== ex.u) report($sformatf("tex_u %h exp %h", got.u, ex.u));
      if (got.v !== ex.v) report($sformatf("tex_v %h exp %h", got.v, ex.v));
      if (got.crn !== ex.crn) report($sformatf("corner %0d exp %0d", got.crn, ex.crn));
      if (got.lst !== ex.lst) report($sformatf("last %b exp %b", got.lst, ex.lst));
      if (got.bad !== ex.bad) report($sformatf("bad_cell %b exp %b", got.bad, ex.bad));
    endtask
  endclass

  logic clk, rst, start, busy, wr_en, strobe, last, bad_cell;
  logic [CELL_W-1:0] cell_col, cell_row;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [SEG_W-1:0] wr_data;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [TEX_W-1:0] tex_u, tex_v;
  logic [1:0] corner;

  tess_scoreboard sb = new();
  int idle_pct;
  int stall_cnt;

  sphere_mesh_tessellator uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input and output monitors
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_cell(cell_col, cell_row);
    if (!rst && strobe)
      sb.check_word('{pos_x, pos_y, pos_z, tex_u, tex_v, corner, last, bad_cell});
  end

  // watchdog: no word moving for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog timeout, %0d words pending", sb.vert_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  task send_cell(int col, int row);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    cell_col <= CELL_W'(col);
    cell_row <= CELL_W'(row);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task drain();
    start <= 0;
    @(posedge clk);
    while (sb.vert_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= SEG_W'(val);
    @(posedge clk);
    sb.write_reg(idx, val);
    wr_en <= 0;
    @(posedge clk);
  endtask

  // random cells: mostly on the grid, some off it; all off it for an empty grid
  task random_cells(int n);
    int sa, sd;
    for (int i = 0; i < n; i++) begin
      sa = (sb.seg_around > SEG_LIMIT) ? SEG_LIMIT : sb.seg_around;
      sd = (sb.seg_down > SEG_LIMIT) ? SEG_LIMIT : sb.seg_down;
      if (sa > 0 && sd > 0 && $urandom_range(99) < 85)
        send_cell($urandom_range(sa - 1), $urandom_range(sd - 1));
      else
        send_cell($urandom_range(255), $urandom_range(255));
    end
  endtask

  int seg_a [7] = '{32, 1, 256, 511, 0, 7, 200};
  int seg_d [7] = '{16, 1, 256, 3, 9, 0, 255};

  initial begin
    rst = 1;
    start = 0;
    cell_col = 0;
    cell_row = 0;
    wr_en = 0;
    wr_index = REG_SEGMENTS_AROUND;
    wr_data = 0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: corners of the default grid, both parities, off-grid cells, then a 256x256 grid
    send_cell(0, 0);
    send_cell(0, 1);
    send_cell(31, 15);
    send_cell(31, 14);
    send_cell(8, 7);
    send_cell(16, 8);
    send_cell(24, 3);
    send_cell(32, 0);
    send_cell(0, 16);
    send_cell(255, 255);
    send_cell(170, 85);
    send_cell(85, 170);
    drain();
    write_reg(REG_UNUSED, 5);
    write_reg(REG_SEGMENTS_AROUND, 256);
    write_reg(REG_SEGMENTS_DOWN, 256);
    send_cell(255, 255);
    send_cell(255, 0);
    send_cell(0, 255);
    send_cell(128, 128);
    send_cell(64, 127);
    drain();

    // random phases over several grid settings and idle mixes
    for (int p = 0; p < 7; p++) begin
      write_reg(REG_SEGMENTS_AROUND, seg_a[p]);
      write_reg(REG_SEGMENTS_DOWN, seg_d[p]);
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 54;
        2: idle_pct = 21;
        default: idle_pct = 54;
      endcase
      random_cells(50);
      drain();
    end
    write_reg(REG_SEGMENTS_AROUND, $urandom_range(1, 256));
    write_reg(REG_SEGMENTS_DOWN, $urandom_range(1, 256));
    idle_pct = 0;
    random_cells(20);
    drain();

    $display("Covered %0d cells (%0d off the grid), %0d vertex words checked",
             sb.cells_seen, sb.bad_seen, sb.words_seen);
    $display("over ten segment settings including 0, 1, 256 and above-limit counts");
    if (sb.errors == 0 && sb.vert_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/smt_pkg.sv
rtl/smt_div.sv
rtl/smt_front.sv
rtl/smt_queue.sv
rtl/smt_back.sv
rtl/sphere_mesh_tessellator.sv
tb/sphere_mesh_tessellator_tb.sv
